@@ rtl/core/nsf_pkg.sv @@
// Package for the NMEA sentence framer: payload structs, frame type,
// operation codes, character constants and the hex digit helper.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package nsf_pkg;

	localparam logic [1:0] OP_DATA  = 2'd0;
	localparam logic [1:0] OP_FIELD = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam int unsigned FRAME_BYTES = 6;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// Up to six bytes produced by one input transaction, plus their count.
	typedef struct packed {
		logic [FRAME_BYTES-1:0][7:0] bytes;
		logic [2:0]                  count;
	} frame_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'd0, nib};
		end else begin
			r = 8'h41 + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/nsf_framer.sv @@
// Input register, sentence state and frame builder of the NMEA framer.
// Depends on nsf_pkg.
`timescale 1ns / 1ps

module nsf_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  nsf_pkg::in_item_t in_item,
	output logic              frame_valid,
	input  logic              frame_ready,
	output nsf_pkg::frame_t   frame
);

	logic              valid_s1;
	nsf_pkg::in_item_t item_s1;
	logic              in_sentence_q;
	logic [7:0]        running_xor_q;
	logic              unused_op;
	logic              take;
	logic [4:0][7:0]   body;
	logic [2:0]        body_len;

	assign unused_op   = (item_s1.op != nsf_pkg::OP_DATA) && (item_s1.op != nsf_pkg::OP_FIELD)
		&& (item_s1.op != nsf_pkg::OP_END);
	assign frame_valid = valid_s1 && !unused_op;
	// An unused op code is dropped without waiting for the serializer.
	assign take        = valid_s1 && (unused_op || frame_ready);
	assign in_ready    = !valid_s1 || take;

	always_comb begin
		body     = '0;
		body_len = 3'd1;
		case (item_s1.op)
			nsf_pkg::OP_DATA: begin
				body[0] = item_s1.data_byte;
			end
			nsf_pkg::OP_FIELD: begin
				body[0] = nsf_pkg::CH_COMMA;
			end
			nsf_pkg::OP_END: begin
				body[0]  = nsf_pkg::CH_STAR;
				body[1]  = nsf_pkg::hex_digit(running_xor_q[7:4]);
				body[2]  = nsf_pkg::hex_digit(running_xor_q[3:0]);
				body[3]  = nsf_pkg::CH_CR;
				body[4]  = nsf_pkg::CH_LF;
				body_len = 3'd5;
			end
			default: begin
				body_len = 3'd0;
			end
		endcase
	end

	always_comb begin
		if (in_sentence_q) begin
			frame.bytes = {8'h00, body};
			frame.count = body_len;
		end else begin
			frame.bytes = {body, nsf_pkg::CH_DOLLAR};
			frame.count = body_len + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			in_sentence_q <= 1'b0;
			running_xor_q <= 8'h00;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (take && !unused_op) begin
				case (item_s1.op)
					nsf_pkg::OP_DATA: begin
						running_xor_q <= running_xor_q ^ item_s1.data_byte;
						in_sentence_q <= 1'b1;
					end
					nsf_pkg::OP_FIELD: begin
						running_xor_q <= running_xor_q ^ nsf_pkg::CH_COMMA;
						in_sentence_q <= 1'b1;
					end
					default: begin
						running_xor_q <= 8'h00;
						in_sentence_q <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ rtl/core/nsf_serializer.sv @@
// Frame register and byte serializer of the NMEA framer: holds one frame
// and hands its bytes out one transaction at a time. Depends on nsf_pkg.
`timescale 1ns / 1ps

module nsf_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_valid,
	output logic               frame_ready,
	input  nsf_pkg::frame_t    frame,
	output logic               out_valid,
	input  logic               out_ready,
	output nsf_pkg::out_item_t out_item
);

	logic                                 busy_q;
	logic [2:0]                           idx_q;
	logic [2:0]                           cnt_q;
	logic [nsf_pkg::FRAME_BYTES-1:0][7:0] bytes_q;
	logic                                 at_last;
	logic                                 load;

	assign at_last     = (idx_q == cnt_q - 3'd1);
	// The next frame loads in the cycle the last byte of this one leaves.
	assign frame_ready = !busy_q || (out_ready && at_last);
	assign load        = frame_valid && frame_ready;

	assign out_valid         = busy_q;
	assign out_item.out_byte = bytes_q[idx_q];
	assign out_item.last     = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (busy_q && out_ready) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= frame.bytes;
			cnt_q   <= frame.count;
		end
	end

endmodule

@@ rtl/core/nmea_sentence_framer.sv @@
// NMEA 0183 sentence framer: an input transaction is held in the framer's input
// register, then in the serializer's frame register, which drives its first byte.
// An item that yields N bytes occupies the serializer until its N bytes have left;
// plain data bytes inside a sentence therefore flow at one item per cycle while out_ready stays high.
// Reset (arst_n low) empties both stages and closes any open sentence.
// Depends on nsf_pkg, nsf_framer and nsf_serializer.
`timescale 1ns / 1ps

module nmea_sentence_framer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nsf_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output nsf_pkg::out_item_t out_item
);

	logic            frame_valid;
	logic            frame_ready;
	nsf_pkg::frame_t frame;

	nsf_framer u_framer (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

	nsf_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

endmodule

@@ verif/tb_nmea_sentence_framer.sv @@
// Self-checking testbench for nmea_sentence_framer: a directed table, then
// random sentences, scored against the predictor or a typed row's own bytes.
// Depends on nsf_pkg and the nmea_sentence_framer RTL.
`timescale 1ns / 1ps

module tb_nmea_sentence_framer;
	import nsf_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DIR_ROWS = 23;
	localparam int RANDOM_ITEMS = 340;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [127:0] HEX_ASCII = "0123456789ABCDEF";

	// One directed row. When typed is set, the first n bytes (leftmost first)
	// are the expected output; otherwise the predictor supplies it.
	typedef struct packed {
		in_item_t        item;
		logic            typed;
		logic [2:0]      n;
		logic [5:0][7:0] chars;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;

	out_item_t pending_chars[$];
	logic sentence_open = 1'b0;
	logic [7:0] running_sum = 8'h00;
	bit idle_on = 1'b1;
	int errors = 0;
	int items_sent = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	dir_row_t dir_table [DIR_ROWS] = '{
		{OP_END, 8'hFF, 1'b1, 3'd6, {CH_DOLLAR, CH_STAR, "0", "0", CH_CR, CH_LF}},
		{OP_UNUSED, 8'hFF, 1'b1, 3'd0, 48'h0},
		{OP_FIELD, 8'h00, 1'b1, 3'd2, {CH_DOLLAR, CH_COMMA, 32'h0}},
		{OP_END, 8'h00, 1'b1, 3'd5, {CH_STAR, "2", "C", CH_CR, CH_LF, 8'h00}},
		{OP_DATA, 8'h00, 1'b1, 3'd2, {CH_DOLLAR, 8'h00, 32'h0}},
		{OP_DATA, 8'hFF, 1'b1, 3'd1, {8'hFF, 40'h0}},
		{OP_DATA, 8'h80, 1'b0, 3'd0, 48'h0},
		{OP_UNUSED, 8'h00, 1'b0, 3'd0, 48'h0},
		{OP_FIELD, 8'hAA, 1'b0, 3'd0, 48'h0},
		{OP_DATA, 8'h7F, 1'b0, 3'd0, 48'h0},
		{OP_FIELD, 8'h55, 1'b0, 3'd0, 48'h0},
		{OP_FIELD, 8'h00, 1'b0, 3'd0, 48'h0},
		{OP_END, 8'h3C, 1'b0, 3'd0, 48'h0},
		{OP_DATA, 8'h01, 1'b0, 3'd0, 48'h0},
		{OP_DATA, 8'h02, 1'b0, 3'd0, 48'h0},
		{OP_END, 8'h00, 1'b0, 3'd0, 48'h0},
		{OP_DATA, 8'hFA, 1'b0, 3'd0, 48'h0},
		{OP_DATA, 8'h0B, 1'b0, 3'd0, 48'h0},
		{OP_END, 8'h00, 1'b0, 3'd0, 48'h0},
		{OP_DATA, 8'h47, 1'b0, 3'd0, 48'h0},
		{OP_END, 8'hAA, 1'b0, 3'd0, 48'h0},
		{OP_END, 8'hFF, 1'b1, 3'd6, {CH_DOLLAR, CH_STAR, "0", "0", CH_CR, CH_LF}},
		{OP_UNUSED, 8'hAA, 1'b0, 3'd0, 48'h0}
	};

	nmea_sentence_framer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] nibble_char(input logic [3:0] nib);
		return HEX_ASCII[8*(15-nib) +: 8];
	endfunction

	// Works out the bytes one transaction produces and advances the sentence
	// state. Bytes come out leftmost first, i.e. chars[5] is the first one.
	task automatic frame_chars(input in_item_t it, output logic [5:0][7:0] chars,
			output int n);
		n = 0;
		chars = '0;
		if (it.op == OP_UNUSED) begin
			return;
		end
		if (!sentence_open) begin
			chars[5-n] = CH_DOLLAR;
			n++;
		end
		case (it.op)
			OP_DATA: begin
				chars[5-n] = it.data_byte;
				n++;
				running_sum ^= it.data_byte;
				sentence_open = 1'b1;
			end
			OP_FIELD: begin
				chars[5-n] = CH_COMMA;
				n++;
				running_sum ^= CH_COMMA;
				sentence_open = 1'b1;
			end
			default: begin
				chars[5-n] = CH_STAR;
				chars[4-n] = nibble_char(running_sum[7:4]);
				chars[3-n] = nibble_char(running_sum[3:0]);
				chars[2-n] = CH_CR;
				chars[1-n] = CH_LF;
				n += 5;
				sentence_open = 1'b0;
				running_sum = 8'h00;
			end
		endcase
	endtask

	task automatic send_item(input in_item_t it, input logic typed, input logic [2:0] n_typed,
			input logic [5:0][7:0] typed_chars);
		int gap;
		int n;
		logic [5:0][7:0] chars;
		out_item_t exp_char;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_ready !== 1'b1);
		frame_chars(it, chars, n);
		if (typed) begin
			chars = typed_chars;
			n = n_typed;
		end
		for (int k = 0; k < n; k++) begin
			exp_char.out_byte = chars[5-k];
			exp_char.last = (k == n - 1);
			pending_chars.insert(pending_chars.size(), exp_char);
		end
		items_sent++;
	endtask

	task automatic send_op(input logic [1:0] op, input logic [7:0] data);
		in_item_t it;
		it.op = op;
		it.data_byte = data;
		send_item(it, 1'b0, 3'd0, '0);
	endtask

	function automatic logic [7:0] random_char();
		if ($urandom_range(0, 3) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	// A well-formed sentence with random content, now and then carrying an
	// ignored opcode in the middle.
	task automatic send_sentence();
		int fields;
		int chars_in_field;
		fields = $urandom_range(1, 5);
		for (int f = 0; f < fields; f++) begin
			chars_in_field = $urandom_range(0, 7);
			for (int b = 0; b < chars_in_field; b++) begin
				if ($urandom_range(0, 29) == 0) begin
					send_op(OP_UNUSED, 8'($urandom_range(0, 255)));
				end
				send_op(OP_DATA, random_char());
			end
			if (f < fields - 1) begin
				send_op(OP_FIELD, 8'($urandom_range(0, 255)));
			end
		end
		send_op(OP_END, 8'($urandom_range(0, 255)));
	endtask

	// Output side: score each accepted transaction, then pick the next ready.
	always @(posedge clk) begin
		out_item_t exp_char;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_chars.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("Unexpected output byte %02h last %0d", out_item.out_byte,
						out_item.last);
				end
			end else begin
				exp_char = pending_chars.pop_front();
				if (out_item.out_byte !== exp_char.out_byte) begin
					errors++;
					if (errors <= 10) begin
						$display("out_byte mismatch: expected %02h, got %02h",
							exp_char.out_byte, out_item.out_byte);
					end
				end
				if (out_item.last !== exp_char.last) begin
					errors++;
					if (errors <= 10) begin
						$display("last mismatch on byte %02h: expected %0d, got %0d",
							exp_char.out_byte, exp_char.last, out_item.last);
					end
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 11) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		bit drained;
		drained = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			send_item(dir_table[r].item, dir_table[r].typed, dir_table[r].n,
				dir_table[r].chars);
		end

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			idle_on = (items_sent < RANDOM_ITEMS - 60);
			// Hold the input off once until the output side has caught up.
			if (!drained && items_sent >= RANDOM_ITEMS / 2) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_chars.size() != 0);
				drained = 1'b1;
			end
			case ($urandom_range(0, 9))
				0: send_op(OP_UNUSED, 8'($urandom_range(0, 255)));
				1: send_op(OP_END, 8'($urandom_range(0, 255)));
				2: send_op(OP_FIELD, 8'($urandom_range(0, 255)));
				default: send_sentence();
			endcase
		end
		in_valid <= 1'b0;

		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_chars.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/nsf_pkg.sv
rtl/core/nsf_framer.sv
rtl/core/nsf_serializer.sv
rtl/core/nmea_sentence_framer.sv
verif/tb_nmea_sentence_framer.sv
